// ----- rtl/core/spdif_pkg.sv -----
// Package for the S/PDIF frame sync and biphase decoder.
// Holds preamble codes, stream positions, the sync state type and the
// structs passed between the scan, control and top-level modules.
package spdif_pkg;

   // Preamble byte codes as sampled at two samples per time slot.
   localparam logic [7:0] PRE_B = 8'hE8;
   localparam logic [7:0] PRE_M = 8'hE2;
   localparam logic [7:0] PRE_W = 8'hE4;

   // Stream geometry of one captured frame.
   localparam int FRAME_BITS  = 128;
   localparam int W_BYTE_POS  = 64;
   localparam int W_OFFSET    = 64;
   localparam int SEARCH_END  = 120;
   localparam int LEFT_START  = 24;
   localparam int RIGHT_START = 88;
   localparam int SAMPLE_BITS = 16;

   // Sync state; the status code 3 is never produced.
   typedef enum logic [1:0] {
      ST_UNSYNCED = 2'd0,
      ST_SYNCING  = 2'd1,
      ST_SYNCED   = 2'd2
   } sync_state_type;

   // Everything derived from one frame alone.
   typedef struct packed {
      logic                          aligned;
      logic                          found;
      logic [7:0]                    offset;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } scan_type;

   // Control decisions for the item being processed.
   typedef struct packed {
      sync_state_type status;
      logic           offset_valid;
      logic           search_failed;
      logic           decode_en;
   } ctrl_type;

   // True for a B or M preamble in either polarity.
   function automatic logic is_bm(input logic [7:0] b);
      is_bm = (b == PRE_B) || (b == ~PRE_B) || (b == PRE_M) || (b == ~PRE_M);
   endfunction

   // True for a W preamble in either polarity.
   function automatic logic is_w(input logic [7:0] b);
      is_w = (b == PRE_W) || (b == ~PRE_W);
   endfunction

endpackage

// ----- rtl/core/spdif_frame_sync_and_biphase_decode.sv -----
// Top level of the S/PDIF frame sync and biphase-mark decoder.
// Instantiates spdif_frame_scan and spdif_sync_ctrl; depends on spdif_pkg.
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+------------------------------------
//   req     | in        | req_valid/stall   | frame_high, frame_low
//   rsp     | out       | rsp_valid/stall   | sync_status, offset_valid,
//           |           |                   | slip_offset, search_failed, samples
//
// Each item passes through the input register and then the result register;
// one item is taken every cycle while the result is not stalled.
// The sync state updates as an item moves into the result register.
// Reset clears the valid flags and puts the controller in unsynced.
// A stalled result holds; the input register keeps accepting until full.
module spdif_frame_sync_and_biphase_decode #(
   parameter int SEARCH_LIMIT = 72
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [63:0]        req_frame_high,
   input  logic [63:0]        req_frame_low,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_sync_status,
   output logic               rsp_offset_valid,
   output logic [7:0]         rsp_slip_offset,
   output logic               rsp_search_failed,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample
);
   import spdif_pkg::*;

   logic        in_valid_ff;
   logic [63:0] in_high_ff;
   logic [63:0] in_low_ff;
   logic        out_valid_ff;
   logic        advance;
   logic        load_in;
   scan_type    scan;
   ctrl_type    ctrl;

   // Handshake: the item in the input register moves when the result slot frees.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load_in) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_high_ff <= req_frame_high;
         in_low_ff  <= req_frame_low;
      end
   end

   // Frame analysis and sync control.
   spdif_frame_scan #(
      .SEARCH_LIMIT(SEARCH_LIMIT)
   ) u_scan (
      .frame_high(in_high_ff),
      .frame_low (in_low_ff),
      .scan      (scan)
   );

   spdif_sync_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .scan   (scan),
      .ctrl   (ctrl)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sync_status   <= ctrl.status;
         rsp_offset_valid  <= ctrl.offset_valid;
         rsp_slip_offset   <= ctrl.offset_valid ? scan.offset : 8'd0;
         rsp_search_failed <= ctrl.search_failed;
         rsp_left_sample   <= ctrl.decode_en ? scan.left : '0;
         rsp_right_sample  <= ctrl.decode_en ? scan.right : '0;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- rtl/core/spdif_frame_scan.sv -----
// Combinational frame analysis: alignment test, preamble search and
// biphase-mark decode of both subframes. Depends on spdif_pkg.
module spdif_frame_scan #(
   parameter int SEARCH_LIMIT = 72
) (
   input  logic [63:0]        frame_high,
   input  logic [63:0]        frame_low,
   output spdif_pkg::scan_type scan
);
   import spdif_pkg::*;

   // Last searched position; the window never reads past stream bit 127.
   localparam int LAST_POS = (SEARCH_LIMIT - 1 < SEARCH_END) ? SEARCH_LIMIT - 1 : SEARCH_END;

   logic                          aligned;
   logic                          found;
   logic [7:0]                    offset;
   logic signed [SAMPLE_BITS-1:0] left;
   logic signed [SAMPLE_BITS-1:0] right;

   // Stream bit p sits at vector bit FRAME_BITS-1-p.
   logic [FRAME_BITS-1:0] stream;
   assign stream = {frame_high, frame_low};

   // Alignment: B/M preamble at byte 0 and W preamble at byte 8.
   logic [7:0] byte0;
   logic [7:0] byte8;
   assign byte0   = stream[FRAME_BITS-1 -: 8];
   assign byte8   = stream[FRAME_BITS-1-W_BYTE_POS -: 8];
   assign aligned = is_bm(byte0) && is_w(byte8);

   // Parallel comparators over the window; the lowest hit position wins.
   always_comb begin
      logic [7:0] b;
      found  = 1'b0;
      offset = '0;
      for (int i = LAST_POS; i >= 1; i--) begin
         b = stream[FRAME_BITS-1-i -: 8];
         if (is_bm(b)) begin
            found  = 1'b1;
            offset = 8'(i);
         end else if (is_w(b)) begin
            found  = 1'b1;
            offset = 8'(i + W_OFFSET);
         end
      end
   end

   // Biphase mark: each bit is the XOR of its slot's two halves, LSB first.
   always_comb begin
      for (int s = 0; s < SAMPLE_BITS; s++) begin
         left[s]  = stream[FRAME_BITS-1-LEFT_START-2*s]
                  ^ stream[FRAME_BITS-2-LEFT_START-2*s];
         right[s] = stream[FRAME_BITS-1-RIGHT_START-2*s]
                  ^ stream[FRAME_BITS-2-RIGHT_START-2*s];
      end
   end

   // Collect the per-frame results.
   assign scan = '{aligned: aligned, found: found, offset: offset,
                   left: left, right: right};

endmodule

// ----- rtl/core/spdif_sync_ctrl.sv -----
// Three-state sync controller: unsynced, syncing and synced.
// Advances once per processed item. Depends on spdif_pkg.
module spdif_sync_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  spdif_pkg::scan_type scan,
   output spdif_pkg::ctrl_type ctrl
);
   import spdif_pkg::*;

   sync_state_type state_ff;
   sync_state_type state_in;
   sync_state_type eff_state;

   // An aligned frame forces synced; a lost alignment drops synced.
   always_comb begin
      if (scan.aligned) begin
         eff_state = ST_SYNCED;
      end else if (state_ff == ST_SYNCED) begin
         eff_state = ST_UNSYNCED;
      end else begin
         eff_state = state_ff;
      end
   end

   // Next state.
   always_comb begin
      unique case (eff_state)
         ST_UNSYNCED: state_in = scan.found ? ST_SYNCING : ST_UNSYNCED;
         ST_SYNCING:  state_in = ST_UNSYNCED;
         ST_SYNCED:   state_in = ST_SYNCED;
         default:     state_in = scan.found ? ST_SYNCING : ST_UNSYNCED;
      endcase
   end

   // Outputs for the current item.
   always_comb begin
      ctrl.status        = state_in;
      ctrl.offset_valid  = 1'b0;
      ctrl.search_failed = 1'b0;
      ctrl.decode_en     = 1'b0;
      unique case (eff_state)
         ST_UNSYNCED: begin
            ctrl.offset_valid  = scan.found;
            ctrl.search_failed = !scan.found;
         end
         ST_SYNCING: begin
         end
         ST_SYNCED: begin
            ctrl.decode_en = 1'b1;
         end
         default: begin
            ctrl.offset_valid  = scan.found;
            ctrl.search_failed = !scan.found;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_UNSYNCED;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for spdif_frame_sync_and_biphase_decode.
// Depends only on spdif_pkg and the block's RTL; it predicts every result
// from the accepted frames and compares each field of every result item.
module testbench;
   import spdif_pkg::*;

   localparam int SEARCH_LIMIT = 72;
   localparam int LATENCY      = 2;
   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_ITEMS   = 100;

   // One predicted result item.
   typedef struct {
      sync_state_type     status;
      logic               offset_valid;
      logic [7:0]         slip_offset;
      logic               search_failed;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } frame_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [63:0]        req_frame_high = '0;
   logic [63:0]        req_frame_low = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_sync_status;
   logic               rsp_offset_valid;
   logic [7:0]         rsp_slip_offset;
   logic               rsp_search_failed;
   logic signed [15:0] rsp_left_sample;
   logic signed [15:0] rsp_right_sample;

   // Predictor state and the queue of results still owed by the block.
   sync_state_type   lock_state = ST_UNSYNCED;
   frame_result_type pending_results[$];

   bit calm = 1'b0;
   int stall_left = 0;
   int failures = 0;
   int frames_sent = 0;
   int results_seen = 0;
   int locks_seen = 0;
   int decodes_seen = 0;
   int misses_seen = 0;

   spdif_frame_sync_and_biphase_decode #(
      .SEARCH_LIMIT(SEARCH_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_high   (req_frame_high),
      .req_frame_low    (req_frame_low),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sync_status  (rsp_sync_status),
      .rsp_offset_valid (rsp_offset_valid),
      .rsp_slip_offset  (rsp_slip_offset),
      .rsp_search_failed(rsp_search_failed),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

   always #5 clock = ~clock;

   // The stream is held as one vector with stream bit 0 in bit 127.
   function automatic logic [7:0] stream_byte(logic [127:0] s, int p);
      return s[127-p -: 8];
   endfunction

   function automatic logic [127:0] put_byte(logic [127:0] s, int p, logic [7:0] b);
      s[127-p -: 8] = b;
      return s;
   endfunction

   // B and M preambles open a frame; W opens the second subframe.
   function automatic logic opens_frame(logic [7:0] b);
      return b == PRE_B || b == 8'(~PRE_B) || b == PRE_M || b == 8'(~PRE_M);
   endfunction

   function automatic logic opens_subframe(logic [7:0] b);
      return b == PRE_W || b == 8'(~PRE_W);
   endfunction

   // Each slot is two stream bits; a transition inside the slot is a one.
   function automatic logic [15:0] biphase_sample(logic [127:0] s, int start);
      logic [15:0] v;
      int k;
      v = '0;
      for (k = 0; k < SAMPLE_BITS; k++)
         v[k] = s[127-start-2*k] ^ s[126-start-2*k];
      return v;
   endfunction

   // Advances the lock state by one frame and returns the result it causes.
   function automatic frame_result_type lock_and_decode(logic [63:0] hi, logic [63:0] lo);
      logic [127:0] s;
      frame_result_type r;
      sync_state_type st;
      logic [7:0] b;
      int i;
      s = {hi, lo};
      r = '{ST_UNSYNCED, 1'b0, 8'd0, 1'b0, 16'sd0, 16'sd0};
      st = lock_state;
      if (opens_frame(stream_byte(s, 0)) && opens_subframe(stream_byte(s, W_BYTE_POS)))
         st = ST_SYNCED;
      else if (st == ST_SYNCED)
         st = ST_UNSYNCED;
      case (st)
         ST_UNSYNCED: begin
            for (i = 1; i < SEARCH_LIMIT && i <= SEARCH_END; i++) begin
               b = stream_byte(s, i);
               if (!r.offset_valid && opens_frame(b)) begin
                  r.offset_valid = 1'b1;
                  r.slip_offset = 8'(i);
               end else if (!r.offset_valid && opens_subframe(b)) begin
                  r.offset_valid = 1'b1;
                  r.slip_offset = 8'(i + W_OFFSET);
               end
            end
            if (r.offset_valid)
               st = ST_SYNCING;
            else
               r.search_failed = 1'b1;
         end
         ST_SYNCING: begin
            st = ST_UNSYNCED;
         end
         default: begin
            r.left = biphase_sample(s, LEFT_START);
            r.right = biphase_sample(s, RIGHT_START);
         end
      endcase
      lock_state = st;
      r.status = st;
      return r;
   endfunction

   // Frame builders.
   function automatic logic [127:0] random_stream();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [7:0] pick_frame_code();
      case ($urandom_range(0, 3))
         0: return PRE_B;
         1: return 8'(~PRE_B);
         2: return PRE_M;
         default: return 8'(~PRE_M);
      endcase
   endfunction

   function automatic logic [7:0] pick_subframe_code();
      return $urandom_range(0, 1) ? PRE_W : 8'(~PRE_W);
   endfunction

   function automatic logic [127:0] encode_sample(logic [127:0] s, int start, logic [15:0] v);
      logic a;
      int k;
      for (k = 0; k < SAMPLE_BITS; k++) begin
         a = 1'($urandom_range(0, 1));
         s[127-start-2*k] = a;
         s[126-start-2*k] = a ^ v[k];
      end
      return s;
   endfunction

   function automatic logic [127:0] aligned_stream(logic [7:0] frame_code,
                                                   logic [7:0] subframe_code,
                                                   logic [15:0] left,
                                                   logic [15:0] right);
      logic [127:0] s;
      s = random_stream();
      s = put_byte(s, 0, frame_code);
      s = put_byte(s, W_BYTE_POS, subframe_code);
      s = encode_sample(s, LEFT_START, left);
      return encode_sample(s, RIGHT_START, right);
   endfunction

   function automatic logic [127:0] random_aligned();
      return aligned_stream(pick_frame_code(), pick_subframe_code(),
                            16'($urandom), 16'($urandom));
   endfunction

   // A slipped frame: some preamble sits inside the search window.
   function automatic logic [127:0] slipped_stream();
      logic [127:0] s;
      s = ($urandom_range(0, 3) == 0) ? '0 : random_stream();
      return put_byte(s, $urandom_range(1, SEARCH_LIMIT - 1),
                      ($urandom_range(0, 2) == 0) ? pick_subframe_code() : pick_frame_code());
   endfunction

   // An aligned frame with one preamble bit flipped, which no longer aligns.
   function automatic logic [127:0] broken_stream();
      logic [127:0] s;
      int p;
      s = random_aligned();
      p = $urandom_range(0, 1) ? $urandom_range(0, 7) : W_BYTE_POS + $urandom_range(0, 7);
      s[127-p] = ~s[127-p];
      return s;
   endfunction

   // Sends one frame; entered and left at a falling edge.
   task automatic send_stream(logic [127:0] s);
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_frame_high <= s[127:64];
      req_frame_low <= s[63:0];
      do
         @(posedge clock);
      while (req_stall);
      pending_results.push_back(lock_and_decode(s[127:64], s[63:0]));
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("mismatch in %s at %0t: got %0h, expected %0h", field, $time, got, want);
      failures++;
   endtask

   // Result receiver stalls in random bursts.
   always @(negedge clock) begin
      if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 11);
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0)
         stall_left--;
   end

   // Compares every accepted result item with the oldest prediction.
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 16'(rsp_sync_status), 16'd0);
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (want.offset_valid)
               locks_seen++;
            if (want.status == ST_SYNCED)
               decodes_seen++;
            if (want.search_failed)
               misses_seen++;
            if (rsp_sync_status !== want.status)
               report_mismatch("sync_status", 16'(rsp_sync_status), 16'(want.status));
            if (rsp_offset_valid !== want.offset_valid)
               report_mismatch("offset_valid", 16'(rsp_offset_valid), 16'(want.offset_valid));
            if (rsp_slip_offset !== want.slip_offset)
               report_mismatch("slip_offset", 16'(rsp_slip_offset), 16'(want.slip_offset));
            if (rsp_search_failed !== want.search_failed)
               report_mismatch("search_failed", 16'(rsp_search_failed),
                               16'(want.search_failed));
            if (rsp_left_sample !== want.left)
               report_mismatch("left_sample", rsp_left_sample, want.left);
            if (rsp_right_sample !== want.right)
               report_mismatch("right_sample", rsp_right_sample, want.right);
         end
      end
   end

   // Searches from reset that find nothing.
   task automatic test_search_after_reset();
      send_stream('0);
      send_stream('1);
   endtask

   // Every preamble code in the search window, four at its edges, each followed by a
   // slipped frame while syncing, which must fall back to unsynced without a search.
   task automatic test_preamble_positions();
      logic [7:0] codes[6];
      int spots[6];
      int i;
      codes = '{PRE_B, 8'(~PRE_B), PRE_M, 8'(~PRE_M), PRE_W, 8'(~PRE_W)};
      spots = '{1, SEARCH_LIMIT - 1, 35, 2, 1, SEARCH_LIMIT - 1};
      for (i = 0; i < 6; i++) begin
         send_stream(put_byte('0, spots[i], codes[i]));
         send_stream(put_byte('0, 3, PRE_B));
      end
      // A preamble just past the search window is not found.
      send_stream(put_byte('1, SEARCH_LIMIT, PRE_B));
   endtask

   // Aligned frames with the sample extremes in both preamble polarities.
   task automatic test_sample_extremes();
      send_stream(aligned_stream(PRE_B, PRE_W, 16'h7FFF, 16'h8000));
      send_stream(aligned_stream(8'(~PRE_M), 8'(~PRE_W), 16'h0000, 16'hFFFF));
      send_stream(aligned_stream(PRE_M, 8'(~PRE_W), 16'h8000, 16'h7FFF));
      send_stream(aligned_stream(8'(~PRE_B), PRE_W, 16'h0001, 16'hFFFE));
   endtask

   // Losing alignment while synced searches the same frame.
   task automatic test_loss_of_sync();
      logic [127:0] s;
      s = put_byte(random_stream(), 0, 8'h00);
      send_stream(put_byte(s, 10, PRE_M));
      send_stream(random_aligned());
      send_stream('0);
   endtask

   // Mostly lock sequences with random content, plus noise and broken frames.
   task automatic test_random_traffic();
      int n;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_stream(slipped_stream());
               n++;
               repeat ($urandom_range(1, 8)) begin
                  send_stream(random_aligned());
                  n++;
               end
               if ($urandom_range(0, 1)) begin
                  send_stream(broken_stream());
                  n++;
               end
            end
            5, 6: begin
               repeat ($urandom_range(1, 6)) begin
                  send_stream(random_aligned());
                  n++;
               end
            end
            7: begin
               send_stream(random_stream());
               n++;
            end
            default: begin
               send_stream(slipped_stream());
               send_stream($urandom_range(0, 1) ? slipped_stream() : broken_stream());
               n += 2;
            end
         endcase
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_search_after_reset();
      test_preamble_positions();
      test_sample_extremes();
      test_loss_of_sync();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("Checked %0d of %0d frames: %0d lock requests, %0d decoded, %0d failed searches.",
               results_seen, frames_sent, locks_seen, decodes_seen, misses_seen);
      if (failures == 0)
         $display("[spdif_frame_sync_and_biphase_decode] OK");
      else
         $display("[spdif_frame_sync_and_biphase_decode] ERROR");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("[spdif_frame_sync_and_biphase_decode] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/spdif_pkg.sv
rtl/core/spdif_frame_scan.sv
rtl/core/spdif_sync_ctrl.sv
rtl/core/spdif_frame_sync_and_biphase_decode.sv
bench/testbench.sv
